FILE: rtl/core/agc_gsm_pkg.sv
`timescale 1ns / 1ps

package agc_gsm_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_SETPOINT = 3'd0;
  localparam logic [2:0] REG_VGA_MIN  = 3'd1;
  localparam logic [2:0] REG_VGA_MAX  = 3'd2;
  localparam logic [2:0] REG_ATT_MIN  = 3'd3;
  localparam logic [2:0] REG_ATT_MAX  = 3'd4;

  // Register reset values.
  localparam logic signed [15:0] SETPOINT_RST = -16'sd7680;
  localparam logic [11:0] VGA_MIN_RST = 12'd1938;
  localparam logic [11:0] VGA_MAX_RST = 12'd2936;
  localparam logic [11:0] ATT_MIN_RST = 12'd3289;
  localparam logic [11:0] ATT_MAX_RST = 12'd3897;

  // Mode codes as seen on the result word.
  localparam logic [1:0] MODE_CODE_IDLE      = 2'd0;
  localparam logic [1:0] MODE_CODE_RAISE_VGA = 2'd1;
  localparam logic [1:0] MODE_CODE_LOWER_VGA = 2'd2;
  localparam logic [1:0] MODE_CODE_RAISE_ATT = 2'd3;

  // Controller mode, one-hot.
  typedef enum logic [3:0] {
    MODE_IDLE      = 4'b0001,
    MODE_RAISE_VGA = 4'b0010,
    MODE_LOWER_VGA = 4'b0100,
    MODE_RAISE_ATT = 4'b1000
  } mode_t;

  // RSSI in Q8.8: floor((s * RSSI_SLOPE - RSSI_OFFSET) / 2^16).
  localparam logic [19:0] RSSI_SLOPE = 20'd709465;
  localparam logic signed [33:0] RSSI_OFFSET = 34'sd576115672;

  // DAC codes: floor((g * SLOPE + OFFSET) / 2^24).
  localparam logic signed [22:0] VGA_SLOPE  = 23'sd933816;
  localparam logic signed [44:0] VGA_OFFSET = 45'sd37308166308;
  localparam logic signed [22:0] ATT_SLOPE  = 23'sd2412747;
  localparam logic signed [44:0] ATT_OFFSET = 45'sd67546413793;

endpackage

FILE: rtl/core/agc_gain_state_machine.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake           | Word
// ---------+-----------+---------------------+----------------------------------------
// in       | input     | in_valid, in_stall  | detector_sample
// out      | output    | out_valid,out_stall | vga_out, att_out, mode_out, check_phase
// cfg      | input     | cfg_wr_en           | cfg_index, cfg_data
//
// Each accepted sample goes through the stages to its result: one stage converts it to RSSI,
// the next computes gain and codes and updates the controller state, which is the result.
// A new sample is accepted every cycle while the output side keeps up.
// Synchronous active-high reset clears the pipeline, mode and phase, loads the register
// defaults and sets the VGA code to its max default and the attenuator code to its min default.
// While out_stall is high a valid result holds and in_stall rises once the RSSI stage is full.
module agc_gain_state_machine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] detector_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] vga_out,
  output logic [11:0] att_out,
  output logic [1:0]  mode_out,
  output logic        check_phase,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import agc_gsm_pkg::*;

  // Configuration registers.
  logic signed [15:0] setpoint_q8;
  logic [11:0] vga_code_min, vga_code_max, att_code_min, att_code_max;

  // Pipeline control.
  logic        rssi_valid;
  logic        out_free;
  logic        advance;
  logic        in_accept;

  // Controller state.
  mode_t       mode, mode_next;
  logic        awaiting_check, awaiting_check_next;
  logic [11:0] vga_code, vga_code_next;
  logic [11:0] att_code, att_code_next;

  // Datapath.
  logic [31:0]        rssi_prod;
  logic signed [33:0] rssi_diff;
  logic signed [17:0] rssi;
  logic signed [18:0] gain;
  logic signed [41:0] vga_prod, att_prod;
  logic signed [44:0] vga_sum, att_sum;
  logic signed [20:0] vga_raw, att_raw;
  logic [11:0]        vga_clamped, att_clamped;
  logic signed [17:0] sp_ext;
  logic               below_sp, above_sp;

  // Handshake: output register empties when taken, RSSI stage moves when output is free.
  assign out_free  = !out_valid || !out_stall;
  assign advance   = rssi_valid && out_free;
  assign in_stall  = rssi_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_q8  <= SETPOINT_RST;
      vga_code_min <= VGA_MIN_RST;
      vga_code_max <= VGA_MAX_RST;
      att_code_min <= ATT_MIN_RST;
      att_code_max <= ATT_MAX_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SETPOINT: setpoint_q8  <= $signed(cfg_data);
        REG_VGA_MIN:  vga_code_min <= cfg_data[11:0];
        REG_VGA_MAX:  vga_code_max <= cfg_data[11:0];
        REG_ATT_MIN:  att_code_min <= cfg_data[11:0];
        REG_ATT_MAX:  att_code_max <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // RSSI stage: floor division by 2^16 is an arithmetic shift.
  assign rssi_prod = 32'(detector_sample) * 32'(RSSI_SLOPE);
  assign rssi_diff = $signed({2'b00, rssi_prod}) - RSSI_OFFSET;

  always_ff @(posedge clk) begin
    if (rst) begin
      rssi_valid <= 1'b0;
    end else if (in_accept) begin
      rssi_valid <= 1'b1;
    end else if (advance) begin
      rssi_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rssi <= rssi_diff[33:16];
    end
  end

  // Needed gain and both candidate DAC codes.
  assign sp_ext  = 18'(setpoint_q8);
  assign gain    = 19'(sp_ext) - 19'(rssi);
  assign vga_prod = 42'(gain) * 42'(VGA_SLOPE);
  assign att_prod = 42'(gain) * 42'(ATT_SLOPE);
  assign vga_sum  = 45'(vga_prod) + VGA_OFFSET;
  assign att_sum  = 45'(att_prod) + ATT_OFFSET;
  assign vga_raw  = vga_sum[44:24];
  assign att_raw  = att_sum[44:24];

  // Clamp to the limits, min applied last so it wins when min exceeds max.
  always_comb begin
    vga_clamped = vga_raw[11:0];
    if (vga_raw > $signed({9'd0, vga_code_max})) begin
      vga_clamped = vga_code_max;
    end
    if ($signed({9'd0, vga_clamped}) < $signed({9'd0, vga_code_min}) ||
        vga_raw < $signed({9'd0, vga_code_min})) begin
      vga_clamped = vga_code_min;
    end
    att_clamped = att_raw[11:0];
    if (att_raw > $signed({9'd0, att_code_max})) begin
      att_clamped = att_code_max;
    end
    if ($signed({9'd0, att_clamped}) < $signed({9'd0, att_code_min}) ||
        att_raw < $signed({9'd0, att_code_min})) begin
      att_clamped = att_code_min;
    end
  end

  assign below_sp = rssi < sp_ext;
  assign above_sp = rssi > sp_ext;

  // Mode decisions and apply/check phases.
  always_comb begin
    mode_next           = mode;
    awaiting_check_next = awaiting_check;
    vga_code_next       = vga_code;
    att_code_next       = att_code;
    if (mode == MODE_IDLE) begin
      if (below_sp && vga_code < vga_code_max) begin
        mode_next = MODE_RAISE_VGA;
      end else if (above_sp && vga_code > vga_code_min) begin
        mode_next = MODE_LOWER_VGA;
      end else if (above_sp) begin
        mode_next = MODE_RAISE_ATT;
      end
      awaiting_check_next = 1'b0;
    end else if (!awaiting_check) begin
      if (mode == MODE_RAISE_ATT) begin
        att_code_next = att_clamped;
      end else begin
        vga_code_next = vga_clamped;
      end
      awaiting_check_next = 1'b1;
    end else begin
      case (mode)
        MODE_RAISE_VGA: begin
          if (!below_sp || vga_code >= vga_code_max) begin
            mode_next = MODE_IDLE;
          end
        end
        MODE_LOWER_VGA: begin
          if (!above_sp) begin
            mode_next = MODE_IDLE;
          end else if (vga_code <= vga_code_min) begin
            mode_next = MODE_RAISE_ATT;
          end
        end
        default: begin
          if (!above_sp || att_code >= att_code_max) begin
            mode_next = MODE_IDLE;
          end
        end
      endcase
      awaiting_check_next = 1'b0;
    end
  end

  // State registers double as the result word; they move only into a free output.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      awaiting_check <= 1'b0;
      vga_code       <= VGA_MAX_RST;
      att_code       <= ATT_MIN_RST;
      out_valid      <= 1'b0;
    end else begin
      if (advance) begin
        mode           <= mode_next;
        awaiting_check <= awaiting_check_next;
        vga_code       <= vga_code_next;
        att_code       <= att_code_next;
        out_valid      <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result word.
  always_comb begin
    case (mode)
      MODE_IDLE:      mode_out = MODE_CODE_IDLE;
      MODE_RAISE_VGA: mode_out = MODE_CODE_RAISE_VGA;
      MODE_LOWER_VGA: mode_out = MODE_CODE_LOWER_VGA;
      MODE_RAISE_ATT: mode_out = MODE_CODE_RAISE_ATT;
      default:        mode_out = MODE_CODE_IDLE;
    endcase
  end

  assign vga_out     = vga_code;
  assign att_out     = att_code;
  assign check_phase = awaiting_check;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import agc_gsm_pkg::*;

  // Fixed-point coefficients of the detector and DAC transfer curves.
  localparam longint RSSI_GAIN = 64'sd709465;
  localparam longint RSSI_BIAS = 64'sd576115672;
  localparam longint VGA_GAIN = 64'sd933816;
  localparam longint VGA_BIAS = 64'sd37308166308;
  localparam longint ATT_GAIN = 64'sd2412747;
  localparam longint ATT_BIAS = 64'sd67546413793;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLDOFF_CYCLES = 120;

  // Sample classes for the random bursts.
  localparam int NEAR_SETPOINT = 0;
  localparam int ABOVE_SETPOINT = 1;
  localparam int BELOW_SETPOINT = 2;
  localparam int ANY_LEVEL = 3;

  // Register settings used by the random phases.
  localparam int CFG_RANDOM = 0;
  localparam int CFG_LOW_EXTREME = 1;
  localparam int CFG_HIGH_EXTREME = 2;
  localparam int CFG_CROSSED = 3;

  typedef struct packed {
    logic [11:0] vga;
    logic [11:0] att;
    logic [1:0]  mode;
    logic        check;
  } agc_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] detector_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] vga_out;
  logic [11:0] att_out;
  logic [1:0]  mode_out;
  logic        check_phase;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Mirror of the configuration registers.
  logic signed [15:0] sp_q8 = SETPOINT_RST;
  logic [11:0] vga_lo = VGA_MIN_RST;
  logic [11:0] vga_hi = VGA_MAX_RST;
  logic [11:0] att_lo = ATT_MIN_RST;
  logic [11:0] att_hi = ATT_MAX_RST;

  // Mirror of the controller state.
  logic [1:0]  ctl_mode = MODE_CODE_IDLE;
  logic        ctl_check_due = 1'b0;
  logic [11:0] ctl_vga = VGA_MAX_RST;
  logic [11:0] ctl_att = ATT_MIN_RST;

  agc_word_t expected_words[$];
  int mismatches = 0;
  int cycle_count = 0;
  bit sender_gaps = 1'b1;
  bit receiver_gaps = 1'b1;
  bit holdoff_request = 1'b0;
  int holdoff_left = 0;

  agc_gain_state_machine i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .detector_sample(detector_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .vga_out(vga_out),
    .att_out(att_out),
    .mode_out(mode_out),
    .check_phase(check_phase),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // RSSI in Q8.8 dBm; the arithmetic shift floors toward minus infinity.
  function automatic longint rssi_q8(input logic [11:0] s);
    longint sl;
    sl = longint'(s);
    return (sl * RSSI_GAIN - RSSI_BIAS) >>> 24 - 8;
  endfunction

  // DAC code from the needed gain, clamped with the min bound applied last.
  function automatic logic [11:0] dac_code(input longint g, input longint slope,
                                           input longint offset, input logic [11:0] lo,
                                           input logic [11:0] hi);
    longint c;
    longint lo_l;
    longint hi_l;
    lo_l = longint'(lo);
    hi_l = longint'(hi);
    c = (g * slope + offset) >>> 24;
    if (c > hi_l) c = hi_l;
    if (c < lo_l) c = lo_l;
    return c[11:0];
  endfunction

  // Advances the controller mirror by one sample and returns the word it shows.
  function automatic agc_word_t predict_agc_step(input logic [11:0] s);
    longint r;
    longint sp;
    longint g;
    agc_word_t w;
    r = rssi_q8(s);
    sp = longint'(sp_q8);
    g = sp - r;
    if (ctl_mode == MODE_CODE_IDLE) begin
      if (r < sp && ctl_vga < vga_hi) ctl_mode = MODE_CODE_RAISE_VGA;
      else if (r > sp && ctl_vga > vga_lo) ctl_mode = MODE_CODE_LOWER_VGA;
      else if (r > sp) ctl_mode = MODE_CODE_RAISE_ATT;
      ctl_check_due = 1'b0;
    end else if (!ctl_check_due) begin
      if (ctl_mode == MODE_CODE_RAISE_ATT) begin
        ctl_att = dac_code(g, ATT_GAIN, ATT_BIAS, att_lo, att_hi);
      end else begin
        ctl_vga = dac_code(g, VGA_GAIN, VGA_BIAS, vga_lo, vga_hi);
      end
      ctl_check_due = 1'b1;
    end else begin
      case (ctl_mode)
        MODE_CODE_RAISE_VGA: begin
          if (r >= sp || ctl_vga >= vga_hi) ctl_mode = MODE_CODE_IDLE;
        end
        MODE_CODE_LOWER_VGA: begin
          if (r <= sp) ctl_mode = MODE_CODE_IDLE;
          else if (ctl_vga <= vga_lo) ctl_mode = MODE_CODE_RAISE_ATT;
        end
        default: begin
          if (r <= sp || ctl_att >= att_hi) ctl_mode = MODE_CODE_IDLE;
        end
      endcase
      ctl_check_due = 1'b0;
    end
    w.vga = ctl_vga;
    w.att = ctl_att;
    w.mode = ctl_mode;
    w.check = ctl_check_due;
    return w;
  endfunction

  // Offers one detector word and records its expected result once accepted.
  task automatic send_sample(input logic [11:0] s);
    if (sender_gaps && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    detector_sample <= s;
    do @(posedge clk); while (in_stall);
    expected_words.push_back(predict_agc_step(s));
  endtask

  // Stops sending and waits until every expected word has been checked.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the caller lowers the write enable after the batch.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_SETPOINT: sp_q8 = data;
      REG_VGA_MIN: vga_lo = data[11:0];
      REG_VGA_MAX: vga_hi = data[11:0];
      REG_ATT_MIN: att_lo = data[11:0];
      REG_ATT_MAX: att_hi = data[11:0];
      default: ;
    endcase
  endtask

  // Writes all five registers once the block is empty; optionally also
  // writes the unused indexes, which the block must ignore.
  task automatic apply_config(input int sp, input int vlo, input int vhi, input int alo,
                              input int ahi, input bit stray);
    int k;
    wait_for_drain();
    if (stray) begin
      for (k = REG_ATT_MAX + 1; k < 8; k++) write_reg(k[2:0], 16'($urandom));
    end
    write_reg(REG_SETPOINT, sp[15:0]);
    write_reg(REG_VGA_MIN, {4'd0, vlo[11:0]});
    write_reg(REG_VGA_MAX, {4'd0, vhi[11:0]});
    write_reg(REG_ATT_MIN, {4'd0, alo[11:0]});
    write_reg(REG_ATT_MAX, {4'd0, ahi[11:0]});
    cfg_wr_en <= 1'b0;
  endtask

  task automatic setup_phase(input int kind);
    int a;
    int b;
    int c;
    int d;
    a = $urandom_range(0, 4095);
    b = $urandom_range(0, 4095);
    c = $urandom_range(0, 4095);
    d = $urandom_range(0, 4095);
    case (kind)
      CFG_LOW_EXTREME: apply_config(-16384, 0, 4095, 0, 4095, 1'b0);
      CFG_HIGH_EXTREME: apply_config(32767, 0, 4095, 0, 4095, 1'b1);
      CFG_CROSSED: begin
        apply_config($urandom_range(0, 49151) - 16384, (a > b) ? a : b, (a > b) ? b : a,
                     (c > d) ? c : d, (c > d) ? d : c, 1'b0);
      end
      default: begin
        apply_config($urandom_range(0, 49151) - 16384, (a < b) ? a : b, (a < b) ? b : a,
                     (c < d) ? c : d, (c < d) ? d : c, 1'b1);
      end
    endcase
  endtask

  // Picks a sample relative to the level that meets the current setpoint.
  function automatic logic [11:0] pick_sample(input int kind);
    int centre;
    int off;
    int s;
    centre = int'(((longint'(sp_q8) <<< 16) + RSSI_BIAS) / RSSI_GAIN);
    case (kind)
      NEAR_SETPOINT: begin
        off = $urandom_range(0, 64);
        s = centre + off - 32;
      end
      ABOVE_SETPOINT: begin
        off = $urandom_range(8, 600);
        s = centre + off;
      end
      BELOW_SETPOINT: begin
        off = $urandom_range(8, 600);
        s = centre - off;
      end
      default: s = $urandom_range(0, 4095);
    endcase
    if (s < 0) s = 0;
    if (s > 4095) s = 4095;
    return s[11:0];
  endfunction

  // Runs of samples on one side of the setpoint keep the controller in a
  // mode long enough to walk through apply and check phases.
  task automatic send_bursts(input int count);
    int sent;
    int kind;
    int len;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(NEAR_SETPOINT, ANY_LEVEL);
      len = $urandom_range(4, 16);
      repeat (len) begin
        send_sample(pick_sample(kind));
        sent++;
      end
    end
  endtask

  // Walks every mode with the reset register values, saturating both codes.
  task automatic test_mode_walk();
    logic [11:0] walk[14] = '{4095, 4095, 4095, 4095, 4095, 0, 0, 0, 0, 0, 0, 4095, 0, 2048};
    foreach (walk[k]) send_sample(walk[k]);
  endtask

  // RSSI exactly at the setpoint must not leave idle or a mode on either side.
  task automatic test_setpoint_equality();
    logic [11:0] level[6] = '{1000, 1000, 1000, 1001, 999, 1000};
    apply_config(int'(rssi_q8(12'd1000)), int'(VGA_MIN_RST), int'(VGA_MAX_RST),
                 int'(ATT_MIN_RST), int'(ATT_MAX_RST), 1'b1);
    foreach (level[k]) send_sample(level[k]);
  endtask

  // Min bounds above the max bounds: the min bound wins in the clamp.
  task automatic test_crossed_limits();
    logic [11:0] level[5] = '{4095, 4095, 4095, 0, 0};
    apply_config($urandom_range(0, 49151) - 16384, 3000, 1000, 4000, 500, 1'b0);
    foreach (level[k]) send_sample(level[k]);
  endtask

  // Random traffic over several register settings, extremes included.
  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 8; phase++) begin
      setup_phase(phase % 4);
      sender_gaps = (phase != 5);
      receiver_gaps = (phase != 5);
      if (phase == 6) begin
        send_bursts(100);
        wait_for_drain();
        send_bursts(100);
      end else begin
        send_bursts(200);
      end
    end
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  // The output side holds off while words keep coming, so the block fills
  // and must stall its input.
  task automatic test_output_holdoff();
    setup_phase(CFG_RANDOM);
    sender_gaps = 1'b0;
    holdoff_request = 1'b1;
    send_bursts(40);
    sender_gaps = 1'b1;
    wait_for_drain();
  endtask

  task automatic check_result();
    agc_word_t w;
    if (expected_words.size() == 0) begin
      $error("result with no sample pending: vga_out %0d att_out %0d", vga_out, att_out);
      mismatches++;
      return;
    end
    w = expected_words.pop_front();
    if (vga_out !== w.vga) begin
      $error("vga_out expected %0d actual %0d", w.vga, vga_out);
      mismatches++;
    end
    if (att_out !== w.att) begin
      $error("att_out expected %0d actual %0d", w.att, att_out);
      mismatches++;
    end
    if (mode_out !== w.mode) begin
      $error("mode_out expected %0d actual %0d", w.mode, mode_out);
      mismatches++;
    end
    if (check_phase !== w.check) begin
      $error("check_phase expected %0d actual %0d", w.check, check_phase);
      mismatches++;
    end
  endtask

  // Result side: checks each accepted word and drives the stall, with an
  // occasional long hold-off counted here.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result();
    if (holdoff_request) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_request = 1'b0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left--;
    end else begin
      out_stall <= receiver_gaps && ($urandom_range(99) < 13);
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_mode_walk();
    test_setpoint_equality();
    test_crossed_limits();
    test_output_holdoff();
    test_random_traffic();
    wait_for_drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
